// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== design/gsm_pkg.sv =====
// ----------------------------------------------------------------------------
// gsm_pkg
// shared types of the generational slot map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gsm_pkg;

  localparam int FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    F_ADD    = 3'd0,
    F_REMOVE = 3'd1,
    F_SET    = 3'd2,
    F_GET    = 3'd3,
    F_HAS    = 3'd4,
    F_CLEAR  = 3'd5
  } func_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_LOAD,
    U_KEY_RD,
    U_KEY_CHK,
    U_KEY_FIN,
    U_GET_RD,
    U_GET_FIN,
    U_SET_WR,
    U_HAS_OK,
    U_RM_RD,
    U_RM_MOVE,
    U_RM_FREE,
    U_ADD_NEW,
    U_ADD_RD,
    U_ADD_CAP,
    U_ADD_WR,
    U_CLR_INIT,
    U_CLR_RD,
    U_CLR_WR,
    U_PUBLISH
  } uop_t;

  typedef struct packed {
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              key_valid;
    logic              is_last;
    logic              add_ok;
    logic              add_new;
    logic              clr_more;
  } status_t;

endpackage

// ===== design/gsm_ram.sv =====
// ----------------------------------------------------------------------------
// gsm_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gsm_datapath.sv =====
// ----------------------------------------------------------------------------
// gsm_datapath
// slot tables, dense store, counters and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gsm_datapath
  import gsm_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int GEN_WIDTH  = 8,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IW-1:0]         in_key_index,
  input  logic [GEN_WIDTH-1:0]  in_key_gen,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  res_ok,
  output logic [IW-1:0]         res_new_key_index,
  output logic [GEN_WIDTH-1:0]  res_new_key_gen,
  output logic [DATA_WIDTH-1:0] res_read_value,
  output logic [CW-1:0]         res_live_count
);

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [FUNC_W-1:0]     func_r;
  logic [IW-1:0]         kidx_r;
  logic [GEN_WIDTH-1:0]  kgen_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r, siu_r, fh_r, clr_i_r;
  logic [GEN_WIDTH-1:0]  gen_q_r;
  logic [CW-1:0]         link_q_r;
  logic                  chk_r, kv_r;
  logic                  ok_w_r;
  logic [IW-1:0]         nidx_w_r;
  logic [GEN_WIDTH-1:0]  ngen_w_r;
  logic [DATA_WIDTH-1:0] rd_w_r;
  logic                  ok_o_r;
  logic [IW-1:0]         nidx_o_r;
  logic [GEN_WIDTH-1:0]  ngen_o_r;
  logic [DATA_WIDTH-1:0] rd_o_r;
  logic [CW-1:0]         live_o_r;

  logic [CW-1:0]         last;
  logic                  gen_we, link_we, dense_we, back_we;
  logic [IW-1:0]         gen_ra, gen_wa, link_wa, dense_ra, dense_wa, back_ra, back_wa;
  logic [GEN_WIDTH-1:0]  gen_wd, gen_rd;
  logic [CW-1:0]         link_wd, link_rd;
  logic [DATA_WIDTH-1:0] dense_wd, dense_rd;
  logic [IW-1:0]         back_wd, back_rd;

  assign last = count_r - CW'(1);

  always_comb begin
    gen_we   = 1'b0;
    link_we  = 1'b0;
    dense_we = 1'b0;
    back_we  = 1'b0;
    gen_ra   = kidx_r;
    gen_wa   = kidx_r;
    gen_wd   = gen_q_r + GEN_WIDTH'(1);
    link_wa  = kidx_r;
    link_wd  = fh_r;
    dense_ra = link_q_r[IW-1:0];
    dense_wa = link_q_r[IW-1:0];
    dense_wd = val_r;
    back_ra  = link_rd[IW-1:0];
    back_wa  = link_q_r[IW-1:0];
    back_wd  = back_rd;
    unique case (cmd.uop)
      U_ADD_RD: gen_ra = fh_r[IW-1:0];
      U_CLR_RD: gen_ra = clr_i_r[IW-1:0];
      U_RM_RD: begin
        dense_ra = last[IW-1:0];
        back_ra  = last[IW-1:0];
      end
      U_SET_WR: dense_we = 1'b1;
      U_RM_MOVE: begin
        dense_we = 1'b1;
        dense_wd = dense_rd;
        back_we  = 1'b1;
        link_we  = 1'b1;
        link_wa  = back_rd;
        link_wd  = link_q_r;
      end
      U_RM_FREE: begin
        gen_we  = 1'b1;
        link_we = 1'b1;
      end
      U_ADD_NEW: begin
        gen_we = 1'b1;
        gen_wa = fh_r[IW-1:0];
        gen_wd = '0;
      end
      U_ADD_WR: begin
        dense_we = 1'b1;
        dense_wa = count_r[IW-1:0];
        back_we  = 1'b1;
        back_wa  = count_r[IW-1:0];
        back_wd  = fh_r[IW-1:0];
        link_we  = 1'b1;
        link_wa  = fh_r[IW-1:0];
        link_wd  = count_r;
      end
      U_CLR_WR: begin
        gen_we  = 1'b1;
        gen_wa  = clr_i_r[IW-1:0];
        gen_wd  = gen_rd + GEN_WIDTH'(1);
        link_we = 1'b1;
        link_wa = clr_i_r[IW-1:0];
        link_wd = clr_i_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  gsm_ram #(.WIDTH(GEN_WIDTH), .DEPTH(SLOTS)) u_gen (
    .clk(clk), .we(gen_we), .waddr(gen_wa), .wdata(gen_wd), .raddr(gen_ra), .rdata(gen_rd)
  );
  gsm_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(gen_ra),
    .rdata(link_rd)
  );
  gsm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_dense (
    .clk(clk), .we(dense_we), .waddr(dense_wa), .wdata(dense_wd), .raddr(dense_ra),
    .rdata(dense_rd)
  );
  gsm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_back (
    .clk(clk), .we(back_we), .waddr(back_wa), .wdata(back_wd), .raddr(back_ra),
    .rdata(back_rd)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      siu_r   <= '0;
      fh_r    <= '0;
      clr_i_r <= '0;
    end else begin
      unique case (cmd.uop)
        U_ADD_NEW: siu_r <= siu_r + CW'(1);
        U_ADD_WR: begin
          count_r <= count_r + CW'(1);
          fh_r    <= link_q_r;
        end
        U_RM_FREE: begin
          count_r <= last;
          fh_r    <= {{(CW-IW){1'b0}}, kidx_r};
        end
        U_CLR_INIT: begin
          count_r <= '0;
          fh_r    <= '0;
          clr_i_r <= '0;
        end
        U_CLR_WR: clr_i_r <= clr_i_r + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    unique case (cmd.uop)
      U_LOAD: begin
        func_r   <= in_func;
        kidx_r   <= in_key_index;
        kgen_r   <= in_key_gen;
        val_r    <= in_value;
        ok_w_r   <= 1'b0;
        nidx_w_r <= '0;
        ngen_w_r <= '0;
        rd_w_r   <= '0;
      end
      U_KEY_CHK: begin
        gen_q_r  <= gen_rd;
        link_q_r <= link_rd;
        chk_r    <= ({{(CW-IW){1'b0}}, kidx_r} < siu_r) && (gen_rd == kgen_r)
                    && (link_rd < count_r);
      end
      U_KEY_FIN: kv_r <= chk_r && (back_rd == kidx_r);
      U_GET_FIN: begin
        rd_w_r <= dense_rd;
        ok_w_r <= 1'b1;
      end
      U_SET_WR, U_HAS_OK, U_RM_FREE, U_CLR_INIT: ok_w_r <= 1'b1;
      U_ADD_NEW: begin
        gen_q_r  <= '0;
        link_q_r <= fh_r + CW'(1);
      end
      U_ADD_CAP: begin
        gen_q_r  <= gen_rd;
        link_q_r <= link_rd;
      end
      U_ADD_WR: begin
        ok_w_r   <= 1'b1;
        nidx_w_r <= fh_r[IW-1:0];
        ngen_w_r <= gen_q_r;
      end
      U_PUBLISH: begin
        ok_o_r   <= ok_w_r;
        nidx_o_r <= nidx_w_r;
        ngen_o_r <= ngen_w_r;
        rd_o_r   <= rd_w_r;
        live_o_r <= count_r;
      end
      default: begin
      end
    endcase
  end

  assign st.func      = func_r;
  assign st.key_valid = kv_r;
  assign st.is_last   = (link_q_r == last);
  assign st.add_ok    = (count_r < SLOTS_C) && (fh_r < SLOTS_C);
  assign st.add_new   = (fh_r == siu_r);
  assign st.clr_more  = (clr_i_r < siu_r);

  assign res_ok            = ok_o_r;
  assign res_new_key_index = nidx_o_r;
  assign res_new_key_gen   = ngen_o_r;
  assign res_read_value    = rd_o_r;
  assign res_live_count    = live_o_r;

  `ASSERT_ALWAYS(a_count_le_open, count_r <= siu_r, "more entries than opened slots")
  `ASSERT_ALWAYS(a_open_le_slots, siu_r <= SLOTS_C, "opened slots beyond capacity")
  `ASSERT_NEXT(a_add_grows, cmd.uop == U_ADD_WR, count_r == $past(count_r) + CW'(1),
    "add did not grow the store")

endmodule

// ===== design/gsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsm_ctrl
// operation sequencer and stream handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gsm_ctrl
  import gsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_KEY_RD, S_KEY_CHK, S_KEY_FIN, S_KEY_DEC,
    S_GET_RD, S_GET_FIN, S_SET_WR, S_HAS_OK, S_RM_RD, S_RM_MOVE, S_RM_FREE,
    S_ADD_NEW, S_ADD_RD, S_ADD_CAP, S_ADD_WR, S_CLR_INIT, S_CLR_CHK,
    S_CLR_RD, S_CLR_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  uop_t   uop;

  always_comb begin
    state_nxt = state_r;
    uop       = U_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          uop       = U_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.func)
          F_ADD: begin
            if (!st.add_ok) state_nxt = S_DONE;
            else if (st.add_new) state_nxt = S_ADD_NEW;
            else state_nxt = S_ADD_RD;
          end
          F_REMOVE, F_SET, F_GET, F_HAS: state_nxt = S_KEY_RD;
          F_CLEAR: state_nxt = S_CLR_INIT;
          default: state_nxt = S_DONE;
        endcase
      end
      S_KEY_RD: begin
        uop       = U_KEY_RD;
        state_nxt = S_KEY_CHK;
      end
      S_KEY_CHK: begin
        uop       = U_KEY_CHK;
        state_nxt = S_KEY_FIN;
      end
      S_KEY_FIN: begin
        uop       = U_KEY_FIN;
        state_nxt = S_KEY_DEC;
      end
      S_KEY_DEC: begin
        if (!st.key_valid) begin
          state_nxt = S_DONE;
        end else begin
          unique case (st.func)
            F_REMOVE: state_nxt = st.is_last ? S_RM_FREE : S_RM_RD;
            F_SET:    state_nxt = S_SET_WR;
            F_GET:    state_nxt = S_GET_RD;
            F_HAS:    state_nxt = S_HAS_OK;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_GET_RD: begin
        uop       = U_GET_RD;
        state_nxt = S_GET_FIN;
      end
      S_GET_FIN: begin
        uop       = U_GET_FIN;
        state_nxt = S_DONE;
      end
      S_SET_WR: begin
        uop       = U_SET_WR;
        state_nxt = S_DONE;
      end
      S_HAS_OK: begin
        uop       = U_HAS_OK;
        state_nxt = S_DONE;
      end
      S_RM_RD: begin
        uop       = U_RM_RD;
        state_nxt = S_RM_MOVE;
      end
      S_RM_MOVE: begin
        uop       = U_RM_MOVE;
        state_nxt = S_RM_FREE;
      end
      S_RM_FREE: begin
        uop       = U_RM_FREE;
        state_nxt = S_DONE;
      end
      S_ADD_NEW: begin
        uop       = U_ADD_NEW;
        state_nxt = S_ADD_WR;
      end
      S_ADD_RD: begin
        uop       = U_ADD_RD;
        state_nxt = S_ADD_CAP;
      end
      S_ADD_CAP: begin
        uop       = U_ADD_CAP;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        uop       = U_ADD_WR;
        state_nxt = S_DONE;
      end
      S_CLR_INIT: begin
        uop       = U_CLR_INIT;
        state_nxt = S_CLR_CHK;
      end
      S_CLR_CHK: state_nxt = st.clr_more ? S_CLR_RD : S_DONE;
      S_CLR_RD: begin
        uop       = U_CLR_RD;
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        uop       = U_CLR_WR;
        state_nxt = S_CLR_CHK;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          uop       = U_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (uop == U_PUBLISH) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.uop    = uop;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `ASSERT_ALWAYS(a_publish_free, (uop != U_PUBLISH) || !out_valid_r || out_tready,
    "result overwritten before taken")
  `ASSERT_NEXT(a_accept_dispatch, in_tvalid && in_tready, state_r == S_DISPATCH,
    "accepted item not dispatched")
  `ASSERT_NEXT(a_publish_valid, uop == U_PUBLISH, out_valid_r && state_r == S_IDLE,
    "published result not shown")

endmodule

// ===== design/generational_slot_map.sv =====
// ----------------------------------------------------------------------------
// generational_slot_map
// generational handle table over a dense value store
// ----------------------------------------------------------------------------
// items arrive on the in_ stream: in_tuser carries the operation (add, remove,
// set, get, has, clear), in_tdata the key and the value. every item gives
// exactly one result item on the out_ stream.
// operations walk a chain of registered reads through the slot,
// back index and dense memories, all single ported for reads.
// one item is processed at a time; in_tready is high only while idle.
// the result sits in an output register, so a new item is taken while an
// earlier result waits; a stalled receiver holds the block only when the
// next result is ready to be published.
// after reset the store is empty and the free list is empty; no memory
// clearing is needed, the tables are written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module generational_slot_map
  import gsm_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int GEN_WIDTH  = 8,
  localparam int IW    = $clog2(SLOTS),
  localparam int CW    = $clog2(SLOTS + 1),
  localparam int IN_W  = ((IW + GEN_WIDTH + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((1 + IW + GEN_WIDTH + DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // key_index, key_gen, value
  input  logic [IN_W-1:0]  in_tdata,
  // func
  input  logic [FUNC_W-1:0] in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // ok, new_key_index, new_key_gen, read_value, live_count
  output logic [OUT_W-1:0] out_tdata
);

  status_t               st;
  cmd_t                  cmd;
  logic                  res_ok;
  logic [IW-1:0]         res_nidx;
  logic [GEN_WIDTH-1:0]  res_ngen;
  logic [DATA_WIDTH-1:0] res_rd;
  logic [CW-1:0]         res_live;

  gsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .st(st), .cmd(cmd)
  );

  gsm_datapath #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH), .GEN_WIDTH(GEN_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_func(in_tuser),
    .in_key_index(in_tdata[IW-1:0]),
    .in_key_gen(in_tdata[IW +: GEN_WIDTH]),
    .in_value(in_tdata[IW+GEN_WIDTH +: DATA_WIDTH]),
    .res_ok(res_ok), .res_new_key_index(res_nidx), .res_new_key_gen(res_ngen),
    .res_read_value(res_rd), .res_live_count(res_live)
  );

  assign out_tdata = OUT_W'({res_live, res_rd, res_ngen, res_nidx, res_ok});

endmodule
